// ===== hdl/swc_pkg.sv =====
// swc_pkg: shared types and constants for the steering window convergence block
// holds the request and result structs, history geometry and register codes
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package swc_pkg;

  // history geometry
  localparam int unsigned HistoryDepth = 64;
  localparam int unsigned IdxW         = $clog2(HistoryDepth);
  localparam int unsigned CntW         = $clog2(HistoryDepth + 1);

  // field widths
  localparam int unsigned AngleW = 16;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned ThrW   = 16;
  localparam int unsigned EcntW  = 7;
  localparam int unsigned CfgW   = 32;

  // configuration register indexes
  localparam logic RegWindowUs  = 1'b0;
  localparam logic RegSpreadThr = 1'b1;

  // configuration reset values
  localparam logic [TimeW-1:0] WindowUsRst  = 32'd1000000;
  localparam logic [ThrW-1:0]  SpreadThrRst = 16'd410;

  typedef struct packed {
    logic                     func;
    logic signed [AngleW-1:0] steer_angle;
    logic [TimeW-1:0]         time_us;
  } in_item_t;

  typedef struct packed {
    logic              converged;
    logic              filled;
    logic [EcntW-1:0]  entry_count;
    logic [AngleW-1:0] spread;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic latch_item;
    logic append;
    logic set_filled;
    logic clr_filled;
    logic drop;
    logic scan_start;
    logic scan_step;
    logic load_result;
  } swc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic req_func;
    logic cnt_zero;
    logic age_ge;
    logic age_gt;
    logic scan_done;
  } swc_stat_t;

endpackage

`default_nettype wire

// ===== hdl/swc_dpath.sv =====
// swc_dpath: history store, pointers, config registers and min/max scan datapath
// driven by swc_ctrl through swc_pkg::swc_cmd_t, reports swc_pkg::swc_stat_t
// depends on swc_pkg
`timescale 1ns / 1ps
`default_nettype none

module swc_dpath (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic                            cfg_idx_i,
  input  wire logic [swc_pkg::CfgW-1:0]        cfg_wdata_i,
  input  wire swc_pkg::in_item_t               in_data_i,
  input  wire swc_pkg::swc_cmd_t               cmd_i,
  output swc_pkg::swc_stat_t                   stat_o,
  output swc_pkg::out_item_t                   out_data_o
);

  typedef struct packed {
    logic signed [swc_pkg::AngleW-1:0] angle;
    logic [swc_pkg::TimeW-1:0]         stamp;
  } entry_t;

  // circular slot of base plus offset
  function automatic logic [swc_pkg::IdxW-1:0] slot_add(
    input logic [swc_pkg::IdxW-1:0] base,
    input logic [swc_pkg::CntW-1:0] off
  );
    logic [swc_pkg::CntW:0] s;
    s = (swc_pkg::CntW+1)'(base) + (swc_pkg::CntW+1)'(off);
    if (s >= (swc_pkg::CntW+1)'(swc_pkg::HistoryDepth)) begin
      s = s - (swc_pkg::CntW+1)'(swc_pkg::HistoryDepth);
    end
    return s[swc_pkg::IdxW-1:0];
  endfunction

  entry_t                           mem [swc_pkg::HistoryDepth];
  entry_t                           rd_data_q;
  logic [swc_pkg::IdxW-1:0]         rd_addr;
  logic [swc_pkg::IdxW-1:0]         wr_addr;

  logic [swc_pkg::TimeW-1:0]        window_q;
  logic [swc_pkg::ThrW-1:0]         thr_q;

  logic signed [swc_pkg::AngleW-1:0] angle_q;
  logic [swc_pkg::TimeW-1:0]        stamp_q;

  logic [swc_pkg::IdxW-1:0]         ptr_q, ptr_d, ptr_inc;
  logic [swc_pkg::CntW-1:0]         cnt_q, cnt_d;
  logic                             filled_q, filled_d;
  logic                             full;

  logic [swc_pkg::CntW-1:0]         k_q, k_d;
  logic                             pend_q, pend_d;
  logic                             first_q, first_d;
  logic signed [swc_pkg::AngleW-1:0] lo_q, lo_d, hi_q, hi_d;
  logic [swc_pkg::AngleW:0]         diff;
  logic [swc_pkg::AngleW-1:0]       spread;
  logic [swc_pkg::TimeW-1:0]        age;

  swc_pkg::out_item_t               res_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= swc_pkg::WindowUsRst;
      thr_q    <= swc_pkg::SpreadThrRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        swc_pkg::RegWindowUs:  window_q <= cfg_wdata_i;
        swc_pkg::RegSpreadThr: thr_q    <= cfg_wdata_i[swc_pkg::ThrW-1:0];
        default: ;
      endcase
    end
  end

  // request holding register
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_item) begin
      angle_q <= in_data_i.steer_angle;
      stamp_q <= in_data_i.time_us;
    end
  end

  assign full    = (cnt_q == swc_pkg::CntW'(swc_pkg::HistoryDepth));
  assign ptr_inc = (ptr_q == swc_pkg::IdxW'(swc_pkg::HistoryDepth - 1)) ?
                   '0 : ptr_q + 1'b1;
  // when full the new sample takes the slot of the dropped oldest one
  assign wr_addr = full ? ptr_q : slot_add(ptr_q, cnt_q);
  assign rd_addr = cmd_i.scan_step ? slot_add(ptr_q, k_q) : ptr_q;

  always_comb begin
    ptr_d    = ptr_q;
    cnt_d    = cnt_q;
    filled_d = filled_q;
    if (cmd_i.append) begin
      if (full) begin
        ptr_d = ptr_inc;
      end else begin
        cnt_d = cnt_q + 1'b1;
      end
    end
    if (cmd_i.drop) begin
      ptr_d = ptr_inc;
      cnt_d = cnt_q - 1'b1;
    end
    if (cmd_i.set_filled) filled_d = 1'b1;
    if (cmd_i.clr_filled) filled_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q    <= '0;
      cnt_q    <= '0;
      filled_q <= 1'b0;
    end else begin
      ptr_q    <= ptr_d;
      cnt_q    <= cnt_d;
      filled_q <= filled_d;
    end
  end

  // history memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.append) begin
      mem[wr_addr] <= '{angle: angle_q, stamp: stamp_q};
    end
    rd_data_q <= mem[rd_addr];
  end

  assign age = stamp_q - rd_data_q.stamp;

  // min/max scan, one read issued per cycle
  always_comb begin
    k_d     = k_q;
    pend_d  = pend_q;
    first_d = first_q;
    lo_d    = lo_q;
    hi_d    = hi_q;
    if (cmd_i.scan_start) begin
      k_d     = '0;
      pend_d  = 1'b0;
      first_d = 1'b1;
    end else if (cmd_i.scan_step) begin
      pend_d = (k_q < cnt_q);
      if (k_q < cnt_q) k_d = k_q + 1'b1;
      if (pend_q) begin
        first_d = 1'b0;
        if (first_q) begin
          lo_d = rd_data_q.angle;
          hi_d = rd_data_q.angle;
        end else begin
          if (rd_data_q.angle < lo_q) lo_d = rd_data_q.angle;
          if (rd_data_q.angle > hi_q) hi_d = rd_data_q.angle;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q     <= '0;
      pend_q  <= 1'b0;
      first_q <= 1'b1;
    end else begin
      k_q     <= k_d;
      pend_q  <= pend_d;
      first_q <= first_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q <= lo_d;
    hi_q <= hi_d;
  end

  assign diff   = (swc_pkg::AngleW+1)'(hi_q) - (swc_pkg::AngleW+1)'(lo_q);
  assign spread = first_q ? '0 : diff[swc_pkg::AngleW-1:0];

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_result) begin
      res_q.converged   <= (cnt_q >= swc_pkg::CntW'(2)) && filled_q && (spread < thr_q);
      res_q.filled      <= filled_q;
      res_q.entry_count <= swc_pkg::EcntW'(cnt_q);
      res_q.spread      <= spread;
    end
  end

  assign out_data_o = res_q;

  assign stat_o.req_func  = in_data_i.func;
  assign stat_o.cnt_zero  = (cnt_q == '0);
  assign stat_o.age_ge    = (age >= window_q);
  assign stat_o.age_gt    = (age > window_q);
  assign stat_o.scan_done = (k_q == cnt_q) && !pend_q;

endmodule

`default_nettype wire

// ===== hdl/swc_ctrl.sv =====
// swc_ctrl: sequencing state machine for record, eviction, scan and result hand-off
// talks to swc_dpath only through swc_pkg::swc_cmd_t and swc_pkg::swc_stat_t
// depends on swc_pkg
`timescale 1ns / 1ps
`default_nettype none

module swc_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  input  wire swc_pkg::swc_stat_t stat_i,
  output swc_pkg::swc_cmd_t       cmd_o
);

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StAppend = 3'd1;
  localparam logic [2:0] StFtRd   = 3'd2;
  localparam logic [2:0] StFtChk  = 3'd3;
  localparam logic [2:0] StEvRd   = 3'd4;
  localparam logic [2:0] StEvChk  = 3'd5;
  localparam logic [2:0] StScInit = 3'd6;
  localparam logic [2:0] StScan   = 3'd7;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       accept;

  assign in_ready_o = (state_q == StIdle);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          cmd_o.latch_item = 1'b1;
          state_d = stat_i.req_func ? StAppend : StScInit;
        end
      end
      StAppend: begin
        cmd_o.append = 1'b1;
        if (stat_i.cnt_zero) begin
          cmd_o.clr_filled = 1'b1;
          state_d = StScInit;
        end else begin
          state_d = StFtRd;
        end
      end
      StFtRd: state_d = StFtChk;
      StFtChk: begin
        if (!stat_i.age_ge) begin
          cmd_o.clr_filled = 1'b1;
          state_d = StScInit;
        end else begin
          cmd_o.set_filled = 1'b1;
          if (stat_i.age_gt) begin
            cmd_o.drop = 1'b1;
            state_d = StEvRd;
          end else begin
            state_d = StScInit;
          end
        end
      end
      StEvRd: state_d = StEvChk;
      StEvChk: begin
        if (!stat_i.cnt_zero && stat_i.age_gt) begin
          cmd_o.drop = 1'b1;
          state_d = StEvRd;
        end else begin
          state_d = StScInit;
        end
      end
      StScInit: begin
        cmd_o.scan_start = 1'b1;
        state_d = StScan;
      end
      StScan: begin
        cmd_o.scan_step = 1'b1;
        if (stat_i.scan_done && (!out_valid_q || out_ready_i)) begin
          cmd_o.load_result = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (cmd_o.load_result) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ===== hdl/steer_window_convergence.sv =====
// sequence: a query only scans the history; a recording request appends and, if the
// history held entries, tests the oldest age and evicts expired entries from the front
// before the scan; throughput: one request at a time, the next taken only once the result
// is loaded, and the load waits while an earlier result is stalled at the output
// reset: async active low, history empty, filled clear, registers at defaults;
// the history memory itself is not cleared
`timescale 1ns / 1ps
`default_nettype none

module steer_window_convergence (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  // configuration write port
  input  wire logic                     cfg_we_i,
  input  wire logic                     cfg_idx_i,
  input  wire logic [swc_pkg::CfgW-1:0] cfg_wdata_i,
  // request channel
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire swc_pkg::in_item_t        in_data_i,
  // result channel
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output swc_pkg::out_item_t            out_data_o
);

  // command and status between sequencer and datapath
  swc_pkg::swc_cmd_t  cmd;
  swc_pkg::swc_stat_t stat;

  // sequencer: record, age test, front eviction, scan, result hand-off;
  // takes a new request while the previous result still waits in the
  // output register
  swc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // datapath: circular history memory, oldest pointer and count,
  // window and threshold registers, min/max accumulator, result register
  swc_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

// ===== hdl/swc_checker.sv =====
// swc_checker: port-level assertions for steer_window_convergence
// bound to the top level below; depends on swc_pkg
`timescale 1ns / 1ps
`default_nettype none

module swc_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_ready_o,
  input wire logic               out_valid_o,
  input wire logic               out_ready_i,
  input wire swc_pkg::out_item_t out_data_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // one request at a time: busy right after an accept
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request accepted back to back");

  a_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.converged |->
      out_data_o.filled && (out_data_o.entry_count >= 7'd2))
    else $error("converged without filled history");

  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.entry_count <= swc_pkg::EcntW'(swc_pkg::HistoryDepth))
    else $error("entry count beyond depth");

  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.entry_count == 7'd0) |-> out_data_o.spread == '0)
    else $error("spread on empty history");

endmodule

bind steer_window_convergence swc_checker u_swc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire

// ===== bench/tb_top.sv =====
// tb_top: self-checking bench for the steering window convergence block
// random and directed requests, with a predictor of the time-stamped history
// depends on swc_pkg and steer_window_convergence
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned StallLimit = 5000;   // cycles with outstanding work but no handshake
  localparam int unsigned DrainCycles = 300;   // quiet time after the last result

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         cfg_we = 1'b0;
  logic                         cfg_idx = swc_pkg::RegWindowUs;
  logic [swc_pkg::CfgW-1:0]     cfg_wdata = '0;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  swc_pkg::in_item_t            in_data = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  swc_pkg::out_item_t           out_data;

  // requests waiting to be driven and results waiting to be seen
  swc_pkg::in_item_t            pend_q[$];
  swc_pkg::out_item_t           exp_q[$];

  int unsigned                  send_idle_pct = 0;
  int unsigned                  recv_idle_pct = 0;
  int unsigned                  err_cnt = 0;
  int unsigned                  quiet_cycles = 0;

  // mirror of the history and of the registers
  logic [swc_pkg::AngleW-1:0]   hist_angle[swc_pkg::HistoryDepth];
  logic [swc_pkg::TimeW-1:0]    hist_time[swc_pkg::HistoryDepth];
  int unsigned                  hist_head = 0;
  int unsigned                  hist_cnt = 0;
  bit                           hist_filled = 1'b0;
  logic [swc_pkg::TimeW-1:0]    win_us = swc_pkg::WindowUsRst;
  logic [swc_pkg::ThrW-1:0]     spread_thr = swc_pkg::SpreadThrRst;

  // random request generator state
  logic [swc_pkg::TimeW-1:0]    gen_time = '0;
  logic [swc_pkg::AngleW-1:0]   gen_base = '0;
  int                           burst_left = 0;
  int                           noise_sel = 0;
  bit                           dense = 1'b0;

  always #6 clk = ~clk;

  steer_window_convergence dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  // drop the oldest held entry
  function automatic void pop_oldest();
    hist_head = (hist_head + 1) % swc_pkg::HistoryDepth;
    hist_cnt--;
  endfunction

  // advance the history by one request and work out the flags it reports
  function automatic swc_pkg::out_item_t step_history(input swc_pkg::in_item_t req);
    swc_pkg::out_item_t         res;
    int unsigned                slot;
    bit                         was_empty;
    logic [swc_pkg::TimeW-1:0]  age;
    int                         lo;
    int                         hi;
    int                         ang;
    res = '0;
    if (req.func) begin
      was_empty = (hist_cnt == 0);
      // full history loses its oldest entry before the append
      if (hist_cnt >= swc_pkg::HistoryDepth) pop_oldest();
      slot = (hist_head + hist_cnt) % swc_pkg::HistoryDepth;
      hist_angle[slot] = req.steer_angle;
      hist_time[slot] = req.time_us;
      hist_cnt++;
      if (was_empty) begin
        hist_filled = 1'b0;
      end else begin
        // ages wrap modulo 2^32
        age = req.time_us - hist_time[hist_head];
        if (age >= win_us) begin
          hist_filled = 1'b1;
          while (hist_cnt > 0 && (req.time_us - hist_time[hist_head]) > win_us) pop_oldest();
        end else begin
          hist_filled = 1'b0;
        end
      end
    end
    lo = 0;
    hi = 0;
    if (hist_cnt > 0) begin
      lo = int'($signed(hist_angle[hist_head]));
      hi = lo;
      for (int unsigned k = 1; k < hist_cnt; k++) begin
        ang = int'($signed(hist_angle[(hist_head + k) % swc_pkg::HistoryDepth]));
        if (ang < lo) lo = ang;
        if (ang > hi) hi = ang;
      end
    end
    res.spread = swc_pkg::AngleW'(hi - lo);
    res.filled = hist_filled;
    res.entry_count = swc_pkg::EcntW'(hist_cnt);
    res.converged = (hist_cnt >= 2) && hist_filled && (res.spread < spread_thr);
    return res;
  endfunction

  // request driver: valid holds until accepted, idles at random between requests
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) exp_q = {exp_q, step_history(in_data)};
      if (!in_valid || in_ready) begin
        if (pend_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data  <= pend_q[0];
          in_valid <= 1'b1;
          pend_q.delete(0);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result side: random back-pressure, then compare against the oldest prediction
  always @(posedge clk) begin
    if (rst_n) begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
      if (out_valid && out_ready) begin
        if (exp_q.size() == 0) begin
          $error("result with no request outstanding: converged %0d filled %0d %s",
                 out_data.converged, out_data.filled,
                 $sformatf("count %0d spread %0d", out_data.entry_count, out_data.spread));
          err_cnt++;
        end else begin
          swc_pkg::out_item_t want;
          want = exp_q[0];
          exp_q.delete(0);
          if (out_data.converged !== want.converged) begin
            $error("converged: expected %0d, got %0d", want.converged, out_data.converged);
            err_cnt++;
          end
          if (out_data.filled !== want.filled) begin
            $error("filled: expected %0d, got %0d", want.filled, out_data.filled);
            err_cnt++;
          end
          if (out_data.entry_count !== want.entry_count) begin
            $error("entry_count: expected %0d, got %0d", want.entry_count,
                   out_data.entry_count);
            err_cnt++;
          end
          if (out_data.spread !== want.spread) begin
            $error("spread: expected %0d, got %0d", want.spread, out_data.spread);
            err_cnt++;
          end
        end
      end
    end
  end

  // watchdog: only counts while something is still owed
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else if (pend_q.size() != 0 || in_valid || exp_q.size() != 0) begin
        quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= StallLimit) begin
          $display("steer_window_convergence verification failed");
          $finish;
        end
      end
    end
  end

  task automatic queue_request(input bit fn, input logic [swc_pkg::AngleW-1:0] ang,
                               input logic [swc_pkg::TimeW-1:0] ts);
    swc_pkg::in_item_t req;
    req.func = fn;
    req.steer_angle = ang;
    req.time_us = ts;
    pend_q = {pend_q, req};
  endtask

  // block idle: nothing pending, nothing in flight, every result seen
  task automatic wait_drained();
    @(negedge clk);
    while (pend_q.size() != 0 || in_valid || exp_q.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [swc_pkg::CfgW-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (idx == swc_pkg::RegWindowUs) win_us = val;
    else spread_thr = val[swc_pkg::ThrW-1:0];
  endtask

  // random request: bursts of dense or sparse timestamps with clustered angles,
  // mixed with jumps, wraps, repeats and backward steps
  function automatic swc_pkg::in_item_t rand_request();
    swc_pkg::in_item_t          req;
    logic [swc_pkg::TimeW-1:0]  lim;
    int unsigned                pick;
    int                         noise;
    if (burst_left == 0) begin
      burst_left = $urandom_range(60, 20);
      dense = 1'($urandom_range(1));
      noise_sel = $urandom_range(4);
      gen_base = swc_pkg::AngleW'($urandom);
    end
    burst_left--;
    pick = $urandom_range(99);
    if (pick < 4) begin
      gen_time = $urandom;
    end else if (pick < 12) begin
      gen_time = gen_time + win_us + $urandom_range(2) - 1;
    end else if (pick < 16) begin
      gen_time = gen_time;
    end else if (pick < 20) begin
      gen_time = gen_time - $urandom_range(1000);
    end else begin
      lim = dense ? (win_us >> 8) : (win_us >> 2);
      if (lim < 3) lim = 3;
      gen_time = gen_time + $urandom_range(lim);
    end
    case (noise_sel)
      0: noise = 0;
      1: noise = 40;
      2: noise = 150;
      3: noise = 800;
      default: noise = -1;
    endcase
    req.func = ($urandom_range(99) < 85);
    req.time_us = gen_time;
    pick = $urandom_range(99);
    if (!req.func || noise < 0 || pick < 5) begin
      req.steer_angle = swc_pkg::AngleW'($urandom);
    end else if (pick < 7) begin
      req.steer_angle = (pick == 5) ? 16'sh8000 : 16'sh7fff;
    end else begin
      req.steer_angle = swc_pkg::AngleW'(int'(gen_base) + int'($urandom_range(2 * noise))
                                         - noise);
    end
    if (!req.func) req.time_us = $urandom;
    return req;
  endfunction

  task automatic run_phase(input logic [swc_pkg::TimeW-1:0] win,
                           input logic [swc_pkg::ThrW-1:0] thr,
                           input int unsigned send_pct, input int unsigned recv_pct,
                           input int unsigned n_req);
    wait_drained();
    write_reg(swc_pkg::RegWindowUs, win);
    write_reg(swc_pkg::RegSpreadThr, swc_pkg::CfgW'(thr));
    @(negedge clk);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int unsigned i = 0; i < n_req; i++) pend_q = {pend_q, rand_request()};
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    send_idle_pct = 35;
    recv_idle_pct = 71;

    // directed part at reset configuration (1 s window, threshold 410)
    queue_request(1'b0, 16'h1234, 32'd77);          // query on an empty history
    queue_request(1'b1, 16'sh7fff, 32'd0);          // first sample, no age test
    queue_request(1'b1, 16'sh8000, 32'd10);         // full-scale spread
    queue_request(1'b0, 16'h0000, 32'hffff_ffff);   // query keeps state
    queue_request(1'b1, 16'sd0, 32'd1000000);       // age exactly one window, nothing evicted
    queue_request(1'b1, 16'sd5, 32'd1000001);       // one past the window, oldest evicted
    queue_request(1'b1, 16'sd10, 32'd2000020);      // evicts all but the new sample
    queue_request(1'b1, 16'sd20, 32'd3000020);      // two entries, filled, tight spread
    queue_request(1'b0, 16'hffff, 32'd0);
    queue_request(1'b1, 16'sd30, 32'd3000000);      // earlier timestamp but inside window
    queue_request(1'b1, 16'sd35, 32'd1000);         // backwards in time reads as a huge age
    queue_request(1'b1, 16'sd40, 32'hffff_fff0);
    queue_request(1'b1, 16'sd45, 32'h0000_0100);    // timestamp wraps forward
    wait_drained();

    // zero window: only samples at the newest timestamp survive
    write_reg(swc_pkg::RegWindowUs, '0);
    @(negedge clk);
    queue_request(1'b1, 16'sd50, 32'h200);
    queue_request(1'b1, 16'sd51, 32'h200);
    wait_drained();

    // zero threshold never converges
    write_reg(swc_pkg::RegSpreadThr, '0);
    @(negedge clk);
    queue_request(1'b1, 16'sd51, 32'h200);
    queue_request(1'b0, 16'sd0, 32'h0);

    // random part: receiver idles more than sender, then the reverse, then no idling
    run_phase(32'd1000000, 16'd410, 35, 71, 240);
    run_phase(32'd1, 16'd0, 35, 71, 230);
    run_phase(32'hffff_ffff, 16'hffff, 71, 35, 230);
    run_phase(32'd5000, 16'd2000, 71, 35, 230);
    run_phase(32'd200, 16'hffff, 0, 0, 230);
    run_phase(32'd1000000, 16'd410, 0, 0, 240);

    wait_drained();
    repeat (DrainCycles) @(posedge clk);
    if (err_cnt == 0) begin
      $display("steer_window_convergence verification clean");
    end else begin
      $display("steer_window_convergence verification failed");
    end
    $finish;
  end

endmodule

// ===== steer_window_convergence.f =====
hdl/swc_pkg.sv
hdl/swc_dpath.sv
hdl/swc_ctrl.sv
hdl/steer_window_convergence.sv
hdl/swc_checker.sv
bench/tb_top.sv
